// ===== design/crbc_pkg.sv =====
// ----------------------------------------------------------------------------
// crbc_pkg
// Shared types, command and register codes, and the square root step for the
// cylinder radial bin classifier.
// ----------------------------------------------------------------------------
package crbc_pkg;

	localparam logic [1:0] CMD_CLASSIFY = 2'd0;
	localparam logic [1:0] CMD_EDGES    = 2'd1;
	localparam logic [1:0] CMD_MAP      = 2'd2;
	localparam logic [1:0] CMD_NONE     = 2'd3;

	localparam logic [2:0] REG_START_X  = 3'd0;
	localparam logic [2:0] REG_START_Y  = 3'd1;
	localparam logic [2:0] REG_START_Z  = 3'd2;
	localparam logic [2:0] REG_AXIS     = 3'd3;
	localparam logic [2:0] REG_LENGTH   = 3'd4;
	localparam logic [2:0] REG_RADIUS   = 3'd5;
	localparam logic [2:0] REG_SCALE    = 3'd6;

	localparam logic [47:0] AXIS_RESET  = 48'd16384;

	// two root bits per stage, 32 root bits
	localparam int SQRT_STAGES = 16;

	typedef struct packed {
		logic        vld;
		logic [1:0]  cmd;
		logic        rej;
		logic [7:0]  idx;
		logic [30:0] lo;
		logic [30:0] hi;
		logic [5:0]  bin;
	} ctl_t;

	typedef struct packed {
		logic [33:0] rem;
		logic [31:0] root;
	} sqrt_t;

	// one digit of the restoring square root
	function automatic sqrt_t sqrt_step(sqrt_t cur, logic [1:0] bits);
		logic [35:0] r2;
		logic [35:0] trial;
		sqrt_t       nxt;
		r2    = {cur.rem, bits};
		trial = {2'b00, cur.root, 2'b01};
		if (r2 >= trial) begin
			nxt.rem  = 34'(r2 - trial);
			nxt.root = {cur.root[30:0], 1'b1};
		end else begin
			nxt.rem  = r2[33:0];
			nxt.root = {cur.root[30:0], 1'b0};
		end
		return nxt;
	endfunction

endpackage

// ===== design/cylinder_radial_bin_classifier_top.sv =====
// ----------------------------------------------------------------------------
// cylinder_radial_bin_classifier_top
// Classifies points into radial bins of a cylinder; loads edge and map tables.
//
//  channel | signals                                   | dir
//  --------+-------------------------------------------+-----
//  in      | in_valid/in_ready, command .. bin_number  | in
//  out     | out_valid/out_ready, in_bin, bin_index    | out
//  cfg     | cfg_we, cfg_index, cfg_data               | in
//
// One item per cycle while the output register is not stalled.
// The pipeline holds the geometry stages, the 16-stage square root and the two table read stages.
// The whole pipeline advances when the output register is empty or drained.
// Reset clears control and the coarse map valid bits; tables need a write.
// Write commands give no result transfer.
// ----------------------------------------------------------------------------
module cylinder_radial_bin_classifier_top #(
	parameter int MAX_BINS     = 64,
	parameter int COARSE_SLOTS = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         command,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	input  logic [7:0]         table_index,
	input  logic [30:0]        lower_edge,
	input  logic [30:0]        upper_edge,
	input  logic [5:0]         bin_number,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               in_bin,
	output logic [6:0]         bin_index,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [47:0]        cfg_data
);

	logic signed [31:0] start_x_q, start_y_q, start_z_q;
	logic [47:0]        axis_q;
	logic [30:0]        length_q, radius_q;
	logic [31:0]        scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
			start_z_q <= '0;
			axis_q    <= crbc_pkg::AXIS_RESET;
			length_q  <= '0;
			radius_q  <= '0;
			scale_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				crbc_pkg::REG_START_X: start_x_q <= cfg_data[31:0];
				crbc_pkg::REG_START_Y: start_y_q <= cfg_data[31:0];
				crbc_pkg::REG_START_Z: start_z_q <= cfg_data[31:0];
				crbc_pkg::REG_AXIS:    axis_q    <= cfg_data;
				crbc_pkg::REG_LENGTH:  length_q  <= cfg_data[30:0];
				crbc_pkg::REG_RADIUS:  radius_q  <= cfg_data[30:0];
				crbc_pkg::REG_SCALE:   scale_q   <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	crbc_pkg::ctl_t ctl_in, ctl_g, ctl_r;
	logic [63:0]    sq;
	logic [31:0]    r;

	always_comb begin
		ctl_in     = '0;
		ctl_in.vld = in_valid && (command != crbc_pkg::CMD_NONE);
		ctl_in.cmd = command;
		ctl_in.idx = table_index;
		ctl_in.lo  = lower_edge;
		ctl_in.hi  = upper_edge;
		ctl_in.bin = bin_number;
	end

	crbc_geom u_geom (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctl_in  (ctl_in),
		.px      (point_x),
		.py      (point_y),
		.pz      (point_z),
		.sx      (start_x_q),
		.sy      (start_y_q),
		.sz      (start_z_q),
		.axis    (axis_q),
		.len     (length_q),
		.rad     (radius_q),
		.ctl_out (ctl_g),
		.sq_out  (sq)
	);

	crbc_isqrt u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctl_in  (ctl_g),
		.sq_in   (sq),
		.ctl_out (ctl_r),
		.r_out   (r)
	);

	crbc_lookup #(
		.MAX_BINS     (MAX_BINS),
		.COARSE_SLOTS (COARSE_SLOTS)
	) u_lookup (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctl_in  (ctl_r),
		.r_in    (r),
		.rad     (radius_q),
		.scale   (scale_q),
		.out_vld (out_valid),
		.hit     (in_bin),
		.bin_out (bin_index)
	);

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !in_bin |-> bin_index == 7'd0)
		else $error("bin_index not zero on a miss");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");

	a_bin_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_bin |-> bin_index <= 7'd64)
		else $error("bin_index out of range");

endmodule

// ===== design/crbc_geom.sv =====
// ----------------------------------------------------------------------------
// crbc_geom
// Axial projection and squared radial distance, seven register stages.
// ----------------------------------------------------------------------------
module crbc_geom (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  crbc_pkg::ctl_t       ctl_in,
	input  logic signed [31:0]   px,
	input  logic signed [31:0]   py,
	input  logic signed [31:0]   pz,
	input  logic signed [31:0]   sx,
	input  logic signed [31:0]   sy,
	input  logic signed [31:0]   sz,
	input  logic [47:0]          axis,
	input  logic [30:0]          len,
	input  logic [30:0]          rad,
	output crbc_pkg::ctl_t       ctl_out,
	output logic [63:0]          sq_out
);

	logic signed [15:0] ux, uy, uz;
	assign ux = axis[15:0];
	assign uy = axis[31:16];
	assign uz = axis[47:32];

	crbc_pkg::ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7;

	logic signed [32:0] dx_s1, dy_s1, dz_s1;
	logic signed [48:0] prx_s2, pry_s2, prz_s2;
	logic signed [32:0] dx_s2, dy_s2, dz_s2;
	logic [30:0]        rd_s3;
	logic signed [32:0] dx_s3, dy_s3, dz_s3;
	logic signed [47:0] qx_s4, qy_s4, qz_s4;
	logic signed [32:0] dx_s4, dy_s4, dz_s4;
	logic signed [31:0] vx_s5, vy_s5, vz_s5;
	logic signed [63:0] sqx_s6, sqy_s6, sqz_s6;
	logic [63:0]        sq_s7;

	// axial coordinate, floor by arithmetic shift
	logic signed [50:0] acc, rd_full, len_x;
	logic               rej_ax;
	assign acc     = 51'(prx_s2) + 51'(pry_s2) + 51'(prz_s2);
	assign rd_full = acc >>> 14;
	assign len_x   = {20'd0, len};
	assign rej_ax  = (rd_full < 0) || (rd_full > len_x);

	// perpendicular components
	logic signed [34:0] vx, vy, vz, rad_x;
	logic               rej_rad;
	assign vx    = 35'(qx_s4 >>> 14) - 35'(dx_s4);
	assign vy    = 35'(qy_s4 >>> 14) - 35'(dy_s4);
	assign vz    = 35'(qz_s4 >>> 14) - 35'(dz_s4);
	assign rad_x = {4'd0, rad};
	assign rej_rad = (vx > rad_x) || (vx < -rad_x) || (vy > rad_x) || (vy < -rad_x)
		|| (vz > rad_x) || (vz < -rad_x);

	// control words with the reject flags folded in
	crbc_pkg::ctl_t ctl_n3, ctl_n5;
	always_comb begin
		ctl_n3     = ctl_s2;
		ctl_n3.rej = ctl_s2.rej | rej_ax;
		ctl_n5     = ctl_s4;
		ctl_n5.rej = ctl_s4.rej | rej_rad;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			ctl_s7 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_n3;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_n5;
			ctl_s6 <= ctl_s5;
			ctl_s7 <= ctl_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1  <= 33'(px) - 33'(sx);
			dy_s1  <= 33'(py) - 33'(sy);
			dz_s1  <= 33'(pz) - 33'(sz);
			prx_s2 <= 49'(dx_s1) * 49'(ux);
			pry_s2 <= 49'(dy_s1) * 49'(uy);
			prz_s2 <= 49'(dz_s1) * 49'(uz);
			dx_s2  <= dx_s1;
			dy_s2  <= dy_s1;
			dz_s2  <= dz_s1;
			rd_s3  <= acc[44:14];
			dx_s3  <= dx_s2;
			dy_s3  <= dy_s2;
			dz_s3  <= dz_s2;
			qx_s4  <= 48'($signed({1'b0, rd_s3})) * 48'(ux);
			qy_s4  <= 48'($signed({1'b0, rd_s3})) * 48'(uy);
			qz_s4  <= 48'($signed({1'b0, rd_s3})) * 48'(uz);
			dx_s4  <= dx_s3;
			dy_s4  <= dy_s3;
			dz_s4  <= dz_s3;
			vx_s5  <= vx[31:0];
			vy_s5  <= vy[31:0];
			vz_s5  <= vz[31:0];
			sqx_s6 <= vx_s5 * vx_s5;
			sqy_s6 <= vy_s5 * vy_s5;
			sqz_s6 <= vz_s5 * vz_s5;
			sq_s7  <= 64'(sqx_s6) + 64'(sqy_s6) + 64'(sqz_s6);
		end
	end

	assign ctl_out = ctl_s7;
	assign sq_out  = sq_s7;

endmodule

// ===== design/crbc_isqrt.sv =====
// ----------------------------------------------------------------------------
// crbc_isqrt
// Pipelined integer square root of a 64-bit value, two root bits per stage.
// ----------------------------------------------------------------------------
module crbc_isqrt (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  crbc_pkg::ctl_t ctl_in,
	input  logic [63:0]    sq_in,
	output crbc_pkg::ctl_t ctl_out,
	output logic [31:0]    r_out
);

	crbc_pkg::sqrt_t acc_s [crbc_pkg::SQRT_STAGES];
	logic [63:0]     val_s [crbc_pkg::SQRT_STAGES];
	crbc_pkg::ctl_t  ctl_s [crbc_pkg::SQRT_STAGES];

	for (genvar g = 0; g < crbc_pkg::SQRT_STAGES; g++) begin : g_stage
		crbc_pkg::sqrt_t prev, mid, nxt;
		logic [63:0]     pv;
		crbc_pkg::ctl_t  pc;

		if (g == 0) begin : g_first
			assign prev = '0;
			assign pv   = sq_in;
			assign pc   = ctl_in;
		end else begin : g_next
			assign prev = acc_s[g-1];
			assign pv   = val_s[g-1];
			assign pc   = ctl_s[g-1];
		end

		assign mid = crbc_pkg::sqrt_step(prev, pv[63-4*g -: 2]);
		assign nxt = crbc_pkg::sqrt_step(mid, pv[61-4*g -: 2]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[g] <= '0;
			end else if (en) begin
				ctl_s[g] <= pc;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				acc_s[g] <= nxt;
				val_s[g] <= pv;
			end
		end
	end

	assign ctl_out = ctl_s[crbc_pkg::SQRT_STAGES-1];
	assign r_out   = acc_s[crbc_pkg::SQRT_STAGES-1].root;

endmodule

// ===== design/crbc_lookup.sv =====
// ----------------------------------------------------------------------------
// crbc_lookup
// Radius check, coarse map lookup, bin edge correction and output register.
// Table writes are done at the stage that reads the table, so they keep
// their order against classify items.
// ----------------------------------------------------------------------------
module crbc_lookup #(
	parameter int MAX_BINS     = 64,
	parameter int COARSE_SLOTS = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  crbc_pkg::ctl_t ctl_in,
	input  logic [31:0]    r_in,
	input  logic [30:0]    rad,
	input  logic [31:0]    scale,
	output logic           out_vld,
	output logic           hit,
	output logic [6:0]     bin_out
);

	localparam int CW = (COARSE_SLOTS > 1) ? $clog2(COARSE_SLOTS) : 1;
	localparam int EW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

	crbc_pkg::ctl_t ctl_s1, ctl_s2, ctl_s3;
	logic [63:0]    m_s1;
	logic [31:0]    r_s1, r_s2, r_s3;
	logic [5:0]     cmap_s2, n_s3;
	logic           cval_s2, nok_s3;
	logic [30:0]    lo_s3, hi_s3;
	logic           vld_q, hit_q;
	logic [6:0]     bin_q;

	logic [5:0]        cmap  [COARSE_SLOTS];
	logic [COARSE_SLOTS-1:0] cval_q;
	logic [30:0]       inner [MAX_BINS];
	logic [30:0]       outer [MAX_BINS];

	// coarse slot
	logic [31:0]   hi32, slot, idx32, n32;
	logic          slot_ok, map_wr, edge_wr, n_ok;
	logic [CW-1:0] caddr, cwaddr;
	logic [EW-1:0] eaddr, ewaddr;
	assign hi32    = m_s1[63:32];
	assign slot    = (hi32 == 32'd0) ? 32'd0 : hi32 - 32'd1;
	assign slot_ok = slot < 32'(COARSE_SLOTS);
	assign caddr   = slot[CW-1:0];

	assign idx32   = 32'(ctl_s1.idx);
	assign cwaddr  = idx32[CW-1:0];
	assign map_wr  = ctl_s1.vld && (ctl_s1.cmd == crbc_pkg::CMD_MAP)
		&& (idx32 < 32'(COARSE_SLOTS));

	// bin edges, indexed by the mapped bin
	logic [31:0] eidx32;
	assign n32     = 32'(cmap_s2);
	assign n_ok    = n32 < 32'(MAX_BINS);
	assign eaddr   = n32[EW-1:0];
	assign eidx32  = 32'(ctl_s2.idx);
	assign ewaddr  = eidx32[EW-1:0];
	assign edge_wr = ctl_s2.vld && (ctl_s2.cmd == crbc_pkg::CMD_EDGES)
		&& (eidx32 < 32'(MAX_BINS));

	// edge check
	logic [31:0] lo_e, hi_e;
	logic        inside_e;
	logic [6:0]  bin_c;
	assign lo_e     = nok_s3 ? {1'b0, lo_s3} : 32'd0;
	assign hi_e     = nok_s3 ? {1'b0, hi_s3} : 32'd0;
	assign inside_e = (r_s3 >= lo_e) && (r_s3 < hi_e);
	assign bin_c    = inside_e ? {1'b0, n_s3} : {1'b0, n_s3} + 7'd1;

	// control words with the reject flags folded in
	crbc_pkg::ctl_t ctl_n1, ctl_n2, ctl_n3;
	always_comb begin
		ctl_n1     = ctl_in;
		ctl_n1.rej = ctl_in.rej | (r_in > {1'b0, rad});
		ctl_n2     = ctl_s1;
		ctl_n2.rej = ctl_s1.rej | ~slot_ok;
		ctl_n3     = ctl_s2;
		ctl_n3.rej = ctl_s2.rej | ~cval_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			cval_q <= '0;
			vld_q  <= 1'b0;
		end else if (en) begin
			ctl_s1 <= ctl_n1;
			ctl_s2 <= ctl_n2;
			ctl_s3 <= ctl_n3;
			if (map_wr) begin
				cval_q[cwaddr] <= 1'b1;
			end
			vld_q <= ctl_s3.vld && (ctl_s3.cmd == crbc_pkg::CMD_CLASSIFY);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1    <= 64'(r_in) * 64'(scale);
			r_s1    <= r_in;
			if (map_wr) begin
				cmap[cwaddr] <= ctl_s1.bin;
			end
			cmap_s2 <= cmap[caddr];
			cval_s2 <= cval_q[caddr];
			r_s2    <= r_s1;
			if (edge_wr) begin
				inner[ewaddr] <= ctl_s2.lo;
				outer[ewaddr] <= ctl_s2.hi;
			end
			lo_s3   <= inner[eaddr];
			hi_s3   <= outer[eaddr];
			n_s3    <= cmap_s2;
			nok_s3  <= n_ok;
			r_s3    <= r_s2;
			hit_q   <= ~ctl_s3.rej;
			bin_q   <= ctl_s3.rej ? 7'd0 : bin_c;
		end
	end

	assign out_vld = vld_q;
	assign hit     = hit_q;
	assign bin_out = bin_q;

endmodule

// ===== tb/cylinder_radial_bin_classifier_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cylinder_radial_bin_classifier_top_test
// Drives classify and table write commands through the valid/ready input,
// predicts each bin result in the testbench and compares every output
// transfer in order. Runs several cylinder settings, random handshake gaps
// and a long output hold-off.
// ----------------------------------------------------------------------------
module cylinder_radial_bin_classifier_top_test;

	localparam int        WATCHDOG   = 4000;
	localparam int        DRAIN      = 40;
	localparam int        N_PHASES   = 8;
	localparam int        PHASE_ITEMS = 190;
	localparam int        N_ROWS     = 21;
	localparam logic signed [31:0] PMAX = 32'sh7fffffff;
	localparam logic signed [31:0] PMIN = 32'sh80000000;
	localparam logic [30:0] EMAX = 31'h7fffffff;

	typedef struct {
		logic [1:0]         cmd;
		logic signed [31:0] px, py, pz;
		logic [7:0]         idx;
		logic [30:0]        lo, hi;
		logic [5:0]         bn;
	} item_t;

	typedef struct {
		item_t      it;
		bit         typed;
		logic       e_in;
		logic [6:0] e_bin;
	} row_t;

	typedef struct {
		logic       hit;
		logic [6:0] bin;
	} bin_result_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         command;
	logic signed [31:0] point_x, point_y, point_z;
	logic [7:0]         table_index;
	logic [30:0]        lower_edge, upper_edge;
	logic [5:0]         bin_number;
	logic               out_valid;
	logic               out_ready;
	logic               in_bin;
	logic [6:0]         bin_index;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [47:0]        cfg_data;

	cylinder_radial_bin_classifier_top u_dut (.*);

	// predictor copy of registers and tables
	logic signed [31:0] st_x, st_y, st_z;
	logic [47:0]        axis_u;
	logic [30:0]        cyl_len, cyl_rad;
	logic [31:0]        cscale;
	logic [30:0]        inner_e [64];
	logic [30:0]        outer_e [64];
	logic [5:0]         cmap [256];
	bit                 cvalid [256];

	bin_result_t expected_bins [$];
	int          mismatches;
	int          idle_mode;
	bit          hold_req;
	int          hold_left;
	int          quiet_cycles;
	row_t        rows [N_ROWS];
	logic [47:0] ph_val [N_PHASES][7];
	int          ph_mode [N_PHASES];

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic longint unsigned root64(longint unsigned v);
		longint unsigned res, bitv;
		res  = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v   = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic bin_result_t classify_point(item_t it);
		bin_result_t     res;
		longint          d [3], u [3], v [3];
		longint          acc, rd;
		longint unsigned sq, r, slot;
		int              n;
		res = '{1'b0, 7'd0};
		d[0] = longint'(it.px) - longint'(st_x);
		d[1] = longint'(it.py) - longint'(st_y);
		d[2] = longint'(it.pz) - longint'(st_z);
		acc = 0;
		for (int i = 0; i < 3; i++) begin
			u[i] = longint'($signed(axis_u[16*i +: 16]));
			acc += d[i] * u[i];
		end
		rd = acc >>> 14;
		if (rd < 0 || rd > longint'(cyl_len))
			return res;
		sq = 0;
		for (int i = 0; i < 3; i++) begin
			v[i] = ((rd * u[i]) >>> 14) - d[i];
			if (v[i] > longint'(cyl_rad) || v[i] < -longint'(cyl_rad))
				return res;
			sq += longint'(v[i] * v[i]);
		end
		r = root64(sq);
		if (r > cyl_rad)
			return res;
		slot = (r * longint'(cscale)) >> 32;
		slot = (slot > 0) ? slot - 1 : 0;
		if (slot >= 256 || !cvalid[slot])
			return res;
		n = cmap[slot];
		if (!(r >= inner_e[n] && r < outer_e[n]))
			n++;
		res.hit = 1'b1;
		res.bin = 7'(n);
		return res;
	endfunction

	function automatic longint sym(longint m);
		longint unsigned x;
		x = {$urandom, $urandom};
		return longint'(x % longint'(2 * m + 1)) - m;
	endfunction

	function automatic row_t mk(logic [1:0] cmd, logic signed [31:0] px, py, pz,
			logic [7:0] idx, logic [30:0] lo, hi, logic [5:0] bn,
			bit typed, logic e_in, logic [6:0] e_bin);
		row_t r;
		r.it    = '{cmd, px, py, pz, idx, lo, hi, bn};
		r.typed = typed;
		r.e_in  = e_in;
		r.e_bin = e_bin;
		return r;
	endfunction

	function automatic item_t rand_item();
		item_t  it;
		int     c, k;
		longint t, m, w;
		it.px  = $urandom;
		it.py  = $urandom;
		it.pz  = $urandom;
		it.idx = 8'($urandom);
		it.lo  = 31'($urandom);
		it.hi  = 31'($urandom);
		it.bn  = 6'($urandom);
		c = $urandom_range(99);
		w = longint'(cyl_rad) / 64;
		if (c < 78) begin
			// point near the axis segment, offsets over many scales
			it.cmd = crbc_pkg::CMD_CLASSIFY;
			t = sym(longint'(cyl_len) * 5 / 8) + longint'(cyl_len) / 2;
			m = (longint'(cyl_rad) + longint'(cyl_rad) / 8) >> $urandom_range(0, 20);
			it.px = 32'(longint'(st_x) + ((t * longint'($signed(axis_u[15:0]))) >>> 14)
				+ sym(m));
			it.py = 32'(longint'(st_y) + ((t * longint'($signed(axis_u[31:16]))) >>> 14)
				+ sym(m));
			it.pz = 32'(longint'(st_z) + ((t * longint'($signed(axis_u[47:32]))) >>> 14)
				+ sym(m));
		end else if (c < 86) begin
			it.cmd = crbc_pkg::CMD_CLASSIFY;
		end else if (c < 93) begin
			it.cmd = crbc_pkg::CMD_EDGES;
			it.idx = 8'($urandom_range(0, 79));
			if ($urandom_range(1)) begin
				k     = it.idx % 64;
				it.lo = 31'(k * w + sym(w / 4 + 1) + w);
				it.hi = 31'((k + 1) * w);
			end
		end else if (c < 98) begin
			it.cmd = crbc_pkg::CMD_MAP;
			if ($urandom_range(1))
				it.bn = 6'((it.idx + 1) / 4);
		end else begin
			it.cmd = crbc_pkg::CMD_NONE;
		end
		return it;
	endfunction

	// one item: optional gap, offer, wait for the transfer, then predict
	task automatic send_item(item_t it, bit typed, logic e_in, logic [6:0] e_bin);
		int          gap, p;
		bin_result_t res;
		p   = (idle_mode == 1) ? 74 : (idle_mode == 3) ? 26 : 0;
		gap = 0;
		while ($urandom_range(99) < p)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		command     <= it.cmd;
		point_x     <= it.px;
		point_y     <= it.py;
		point_z     <= it.pz;
		table_index <= it.idx;
		lower_edge  <= it.lo;
		upper_edge  <= it.hi;
		bin_number  <= it.bn;
		do @(posedge clk); while (!in_ready);
		case (it.cmd)
			crbc_pkg::CMD_CLASSIFY: begin
				res = typed ? bin_result_t'{e_in, e_bin} : classify_point(it);
				expected_bins.push_back(res);
			end
			crbc_pkg::CMD_EDGES: begin
				if (it.idx < 64) begin
					inner_e[it.idx] = it.lo;
					outer_e[it.idx] = it.hi;
				end
			end
			crbc_pkg::CMD_MAP: begin
				cmap[it.idx]   = it.bn;
				cvalid[it.idx] = 1'b1;
			end
			default: ;
		endcase
	endtask

	task automatic write_reg(logic [2:0] idx, logic [47:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			crbc_pkg::REG_START_X: st_x   = val[31:0];
			crbc_pkg::REG_START_Y: st_y   = val[31:0];
			crbc_pkg::REG_START_Z: st_z   = val[31:0];
			crbc_pkg::REG_AXIS:    axis_u = val;
			crbc_pkg::REG_LENGTH:  cyl_len = val[30:0];
			crbc_pkg::REG_RADIUS:  cyl_rad = val[30:0];
			crbc_pkg::REG_SCALE:   cscale = val[31:0];
			default: ;
		endcase
	endtask

	// write commands give no result, so wait out the pipeline as well
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_bins.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	// output side: check, then decide ready for the next edge
	always @(posedge clk) begin
		bin_result_t e;
		int          q;
		if (arst_n && out_valid && out_ready) begin
			if (expected_bins.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transfer: in_bin=%0d bin_index=%0d",
						in_bin, bin_index);
			end else begin
				e = expected_bins.pop_front();
				if (in_bin !== e.hit || bin_index !== e.bin) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected in_bin=%0d bin_index=%0d, got %0d %0d",
							e.hit, e.bin, in_bin, bin_index);
				end
			end
		end
		q = (idle_mode == 2) ? 74 : (idle_mode == 3) ? 26 : 0;
		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = 300;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= q);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG) begin
			$display("cylinder_radial_bin_classifier_top verification failed");
			$finish;
		end
	end

	initial begin
		item_t  it;
		longint rad;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		out_ready   = 1'b0;
		command     = crbc_pkg::CMD_NONE;
		point_x     = '0;
		point_y     = '0;
		point_z     = '0;
		table_index = '0;
		lower_edge  = '0;
		upper_edge  = '0;
		bin_number  = '0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		mismatches   = 0;
		idle_mode    = 0;
		hold_req     = 1'b0;
		hold_left    = 0;
		quiet_cycles = 0;
		st_x = '0; st_y = '0; st_z = '0;
		axis_u = crbc_pkg::AXIS_RESET;
		cyl_len = '0; cyl_rad = '0; cscale = '0;
		foreach (cvalid[i]) cvalid[i] = 1'b0;

		// reset settings: length and radius 0, so only r = 0 on the axis start survives
		rows = '{
			mk(crbc_pkg::CMD_CLASSIFY, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0), // slot never written
			mk(crbc_pkg::CMD_CLASSIFY, PMAX, 0, 0, 0, 0, 0, 0, 1, 0, 0), // beyond length
			mk(crbc_pkg::CMD_CLASSIFY, PMIN, 0, 0, 0, 0, 0, 0, 1, 0, 0), // behind start
			mk(crbc_pkg::CMD_CLASSIFY, 0, PMAX, PMIN, 0, 0, 0, 0, 1, 0, 0), // beyond radius
			mk(crbc_pkg::CMD_CLASSIFY, 0, 0, PMAX, 0, 0, 0, 0, 1, 0, 0),
			mk(crbc_pkg::CMD_NONE, PMAX, PMAX, PMAX, 8'hff, EMAX, EMAX, 6'h3f, 0, 0, 0),
			mk(crbc_pkg::CMD_EDGES, 0, 0, 0, 8'hff, EMAX, EMAX, 0, 0, 0, 0), // ignored
			mk(crbc_pkg::CMD_EDGES, 0, 0, 0, 8'd64, EMAX, EMAX, 0, 0, 0, 0), // ignored
			mk(crbc_pkg::CMD_EDGES, 0, 0, 0, 8'd0, 0, 31'd5, 0, 0, 0, 0),
			mk(crbc_pkg::CMD_MAP, 0, 0, 0, 8'd0, 0, 0, 6'd0, 0, 0, 0),
			mk(crbc_pkg::CMD_CLASSIFY, 0, 0, 0, 0, 0, 0, 0, 1, 1, 7'd0),
			mk(crbc_pkg::CMD_MAP, 0, 0, 0, 8'hff, 0, 0, 6'h3f, 0, 0, 0),
			mk(crbc_pkg::CMD_EDGES, 0, 0, 0, 8'd0, 0, 0, 0, 0, 0, 0),
			mk(crbc_pkg::CMD_CLASSIFY, 0, 0, 0, 0, 0, 0, 0, 1, 1, 7'd1), // next bin taken
			mk(crbc_pkg::CMD_EDGES, 0, 0, 0, 8'd63, EMAX, EMAX, 0, 0, 0, 0),
			mk(crbc_pkg::CMD_MAP, 0, 0, 0, 8'd0, 0, 0, 6'h3f, 0, 0, 0),
			mk(crbc_pkg::CMD_CLASSIFY, 0, 0, 0, 0, 0, 0, 0, 1, 1, 7'd64), // bin past table
			mk(crbc_pkg::CMD_EDGES, 0, 0, 0, 8'd63, 0, EMAX, 0, 0, 0, 0),
			mk(crbc_pkg::CMD_CLASSIFY, 0, 0, 0, 0, 0, 0, 0, 1, 1, 7'd63),
			mk(crbc_pkg::CMD_CLASSIFY, -1, 0, 0, 0, 0, 0, 0, 1, 0, 0),
			mk(crbc_pkg::CMD_CLASSIFY, 1, 0, 0, 0, 0, 0, 0, 1, 0, 0)
		};

		// start x/y/z, axis, length, radius, coarse scale
		ph_val[0] = '{0, 0, 0, 48'h000000004000, 100 << 16, 10 << 16, (64'd1 << 40) / (10 << 16)};
		ph_val[1] = '{5 << 16, 48'hfffffffd0000 & 48'hffffffff, 7 << 16, 48'h0000c0000000,
			50 << 16, 3 << 16, (64'd1 << 40) / (3 << 16)};
		ph_val[2] = '{32'h7fffffff, 32'h80000000, 0, 48'h400000000000,
			EMAX, EMAX, 32'hffffffff};
		ph_val[3] = '{32'h00123456, 32'hffff0000, 32'h00010000, 0, 0, 0, 0};
		ph_val[4] = '{32'h00030000, 32'hfffe0000, 0, 48'({$urandom, $urandom}),
			1000 << 16, 20 << 16, $urandom};
		ph_val[5] = '{32'hfff00000, 32'h00200000, 32'h00001234, 48'h00002d412d41,
			300 << 16, 8 << 16, (64'd1 << 40) / (8 << 16)};
		ph_val[6] = '{32'h80000000, 32'h80000000, 32'h80000000, 48'h00000000c000,
			200 << 16, 2 << 16, (64'd1 << 40) / (2 << 16)};
		ph_val[7] = '{0, 0, 0, 48'h000000004000, 40 << 16, 1 << 16, (64'd1 << 41) / (1 << 16)};
		ph_mode = '{0, 1, 2, 3, 2, 0, 1, 3};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			send_item(rows[i].it, rows[i].typed, rows[i].e_in, rows[i].e_bin);
		drain();

		// every bin edge is loaded before any map slot can point at it
		rad = 10 << 16;
		for (int k = 0; k < 64; k++) begin
			it = rand_item();
			it.cmd = crbc_pkg::CMD_EDGES;
			it.idx = 8'(k);
			it.lo  = 31'(k * rad / 64);
			it.hi  = 31'((k + 1) * rad / 64);
			send_item(it, 0, 0, 0);
		end
		for (int s = 0; s < 256; s++) begin
			it = rand_item();
			it.cmd = crbc_pkg::CMD_MAP;
			it.idx = 8'(s);
			it.bn  = ($urandom_range(7) == 0) ? 6'($urandom) : 6'((s + 1) / 4);
			send_item(it, 0, 0, 0);
		end
		drain();

		for (int p = 0; p < N_PHASES; p++) begin
			for (int r = 0; r < 7; r++)
				write_reg(3'(r), ph_val[p][r]);
			cfg_we    <= 1'b0;
			idle_mode  = ph_mode[p];
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 4 && n == 40)
					hold_req = 1'b1;
				send_item(rand_item(), 0, 0, 0);
			end
			drain();
		end

		if (mismatches == 0 && expected_bins.size() == 0)
			$display("cylinder_radial_bin_classifier_top verification clean");
		else
			$display("cylinder_radial_bin_classifier_top verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/crbc_pkg.sv
design/crbc_geom.sv
design/crbc_isqrt.sv
design/crbc_lookup.sv
design/cylinder_radial_bin_classifier_top.sv
tb/cylinder_radial_bin_classifier_top_test.sv
